// File: rtl/i2d_pkg.sv
// Shared types and constants for the 128-bit signed binary to decimal converter.
// Used by i2d_bcd_unit, i2d_seq and int128_to_decimal_digits_top; no dependencies.
package i2d_pkg;

  localparam int MAG_BITS  = 128;
  localparam int HALF_BITS = 64;
  localparam int CNT_W     = 7;
  localparam int DIG_W     = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // Commands from the sequencer to the shift-and-adjust unit
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_out;
  } unit_cmd_t;

  // Add three to a BCD digit of five or more ahead of a left shift
  function automatic logic [DIG_W-1:0] bcd_adjust(input logic [DIG_W-1:0] d);
    logic [DIG_W-1:0] r;
    r = (d >= DIG_W'(5)) ? d + DIG_W'(3) : d;
    return r;
  endfunction

endpackage

// File: rtl/i2d_bcd_unit.sv
// Shared shift-and-adjust unit: magnitude shift register plus BCD digit register.
// Depends on i2d_pkg for the command struct and the digit adjust function.
module i2d_bcd_unit #(
  parameter int DIGITS = 39
) (
  input  logic                            clk,
  input  logic [i2d_pkg::HALF_BITS-1:0]   value_high,
  input  logic [i2d_pkg::HALF_BITS-1:0]   value_low,
  input  i2d_pkg::unit_cmd_t              cmd,
  output logic [i2d_pkg::DIG_W-1:0]       top_digit
);

  localparam int BCD_W = DIGITS * i2d_pkg::DIG_W;

  logic [i2d_pkg::MAG_BITS-1:0] mag;
  logic [i2d_pkg::MAG_BITS-1:0] mag_in;
  logic [BCD_W-1:0]             bcd;
  logic [BCD_W-1:0]             bcd_adj;

  // Take the magnitude: negate when the sign bit is set (the most negative value wraps to 2^127)
  assign mag_in = value_high[i2d_pkg::HALF_BITS-1] ?
                  (~{value_high, value_low} + i2d_pkg::MAG_BITS'(1)) :
                  {value_high, value_low};

  // Adjust every digit independently before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*i2d_pkg::DIG_W +: i2d_pkg::DIG_W] =
        i2d_pkg::bcd_adjust(bcd[i*i2d_pkg::DIG_W +: i2d_pkg::DIG_W]);
    end
  end

  // Load, shift one magnitude bit into the digits, or shift a digit out at the top
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (cmd.dabble) begin
      mag <= {mag[i2d_pkg::MAG_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], mag[i2d_pkg::MAG_BITS-1]};
    end else if (cmd.shift_out) begin
      bcd <= {bcd[BCD_W-i2d_pkg::DIG_W-1:0], {i2d_pkg::DIG_W{1'b0}}};
    end
  end

  assign top_digit = bcd[BCD_W-1 -: i2d_pkg::DIG_W];

endmodule

// File: rtl/i2d_seq.sv
// Sequencer: input handshake, conversion bit counter, leading-zero skip and output register.
// Depends on i2d_pkg for the state type and the unit command struct.
module i2d_seq #(
  parameter int DIGITS = 39
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       sign,
  input  logic [i2d_pkg::DIG_W-1:0]  top_digit,
  output i2d_pkg::unit_cmd_t         cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       is_minus,
  output logic [i2d_pkg::DIG_W-1:0]  digit,
  output logic                       last
);

  localparam int REM_W = $clog2(DIGITS + 1);

  i2d_pkg::state_t             state;
  i2d_pkg::state_t             state_next;
  logic [i2d_pkg::CNT_W-1:0]   cnt;
  logic [REM_W-1:0]            rem;
  logic                        neg;
  logic                        can_load;
  logic                        out_load;
  logic                        out_minus_d;
  logic [i2d_pkg::DIG_W-1:0]   out_digit_d;
  logic                        out_last_d;
  logic                        conv_done;
  logic                        skip_zero;

  assign can_load  = !out_valid || out_ready;
  assign conv_done = (cnt == i2d_pkg::CNT_W'(i2d_pkg::MAG_BITS - 1));
  assign skip_zero = (top_digit == '0) && (rem > REM_W'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      i2d_pkg::ST_IDLE:  if (in_valid) state_next = i2d_pkg::ST_CONV;
      i2d_pkg::ST_CONV:  if (conv_done) state_next = i2d_pkg::ST_SKIP;
      i2d_pkg::ST_SKIP: begin
        if (!skip_zero) state_next = neg ? i2d_pkg::ST_SIGN : i2d_pkg::ST_DIGIT;
      end
      i2d_pkg::ST_SIGN:  if (can_load) state_next = i2d_pkg::ST_DIGIT;
      i2d_pkg::ST_DIGIT: if (can_load && rem == REM_W'(1)) state_next = i2d_pkg::ST_IDLE;
      default:           state_next = i2d_pkg::ST_IDLE;
    endcase
  end

  // Unit commands and output item selection
  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    out_minus_d = 1'b0;
    out_digit_d = '0;
    out_last_d  = 1'b0;
    unique case (state)
      i2d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      i2d_pkg::ST_CONV: cmd.dabble = 1'b1;
      i2d_pkg::ST_SKIP: cmd.shift_out = skip_zero;
      i2d_pkg::ST_SIGN: begin
        out_load    = can_load;
        out_minus_d = 1'b1;
      end
      i2d_pkg::ST_DIGIT: begin
        out_load      = can_load;
        out_digit_d   = top_digit;
        out_last_d    = (rem == REM_W'(1));
        cmd.shift_out = can_load;
      end
      default: ;
    endcase
  end

  // Advance state, bit counter and remaining digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2d_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == i2d_pkg::ST_IDLE && in_valid) begin
      cnt <= '0;
      neg <= sign;
    end else if (state == i2d_pkg::ST_CONV) begin
      cnt <= cnt + i2d_pkg::CNT_W'(1);
    end
    if (state == i2d_pkg::ST_CONV) begin
      rem <= REM_W'(DIGITS);
    end else if (cmd.shift_out) begin
      rem <= rem - REM_W'(1);
    end
  end

  // Hold the output item until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      is_minus <= out_minus_d;
      digit    <= out_digit_d;
      last     <= out_last_d;
    end
  end

`ifndef ASSERT_OFF
  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == i2d_pkg::ST_SIGN) |-> neg)
    else $error("sign item issued for a non-negative value");

  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == i2d_pkg::ST_CONV && cnt == '0))
    else $error("accepted item did not start conversion");

  a_digit_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == i2d_pkg::ST_DIGIT) |-> (rem != '0))
    else $error("digit emission ran past the digit count");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last_d) |=> (state == i2d_pkg::ST_IDLE))
    else $error("final item issued without returning to idle");
`endif

endmodule

// File: rtl/int128_to_decimal_digits_top.sv
// Top level of the signed 128-bit binary to decimal digit stream converter.
// Instantiates i2d_seq and i2d_bcd_unit; uses i2d_pkg.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+----------------------------------
//   in      | in_valid / in_ready  | value_high[63:0], value_low[63:0]
//   out     | out_valid / out_ready| is_minus, digit[3:0], last
//
// Steps: an item is accepted, its 128 magnitude bits are shifted one at a time
// into the shared BCD unit with a digit adjust ahead of each shift, then leading
// zeros are dropped and the digits issued, with a sign item ahead of them for a
// negative value.
// in_ready is high only while the sequencer is idle.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output register.
// A stalled output holds the sequencer in place; the output register lets the
// next item be accepted while the final digit still waits.
module int128_to_decimal_digits_top #(
  parameter int DIGITS = 39
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [i2d_pkg::HALF_BITS-1:0]   value_high,
  input  logic [i2d_pkg::HALF_BITS-1:0]   value_low,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            is_minus,
  output logic [i2d_pkg::DIG_W-1:0]       digit,
  output logic                            last
);

  i2d_pkg::unit_cmd_t          cmd;
  logic [i2d_pkg::DIG_W-1:0]   top_digit;

  i2d_seq #(
    .DIGITS (DIGITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sign      (value_high[i2d_pkg::HALF_BITS-1]),
    .top_digit (top_digit),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_minus  (is_minus),
    .digit     (digit),
    .last      (last)
  );

  i2d_bcd_unit #(
    .DIGITS (DIGITS)
  ) u_bcd (
    .clk        (clk),
    .value_high (value_high),
    .value_low  (value_low),
    .cmd        (cmd),
    .top_digit  (top_digit)
  );

endmodule
